FILE: rtl/rfl_pkg.sv
package rfl_pkg;

  // Field widths of the words on the three channels.
  localparam int COORD_W    = 16;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Signed working width for window bounds and displacement costs.
  localparam int CALC_W = 20;

  localparam int DEF_NUM_ROWS   = 1024;
  localparam int DEF_MAX_HEIGHT = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LEFT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_RIGHT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BOTTOM = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_TOP    = CFG_IDX_W'(3);

  localparam logic [COORD_W-1:0] REGION_RIGHT_RST = 16'hFFFF;
  localparam logic [COORD_W-1:0] REGION_TOP_RST   = 16'd1023;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR,
    OP_SWEEP,
    OP_ACCEPT,
    OP_SETUP_A,
    OP_SETUP_B,
    OP_ROW,
    OP_READ,
    OP_MAX,
    OP_COST,
    OP_PICK,
    OP_WR_INIT,
    OP_WRITE,
    OP_EMIT
  } op_e;

  // Jump conditions of the control word.
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_ITEM,
    C_NO_PASS,
    C_SWEEP_MORE,
    C_ROW_PAST,
    C_K_MORE,
    C_NO_ANY,
    C_OUT_FREE
  } cond_e;

  localparam int STEP_W = 4;

  // Program addresses.
  localparam logic [STEP_W-1:0] S_CLR        = 4'd0;
  localparam logic [STEP_W-1:0] S_SWEEP_RST  = 4'd1;
  localparam logic [STEP_W-1:0] S_IDLE       = 4'd2;
  localparam logic [STEP_W-1:0] S_SETUP_A    = 4'd3;
  localparam logic [STEP_W-1:0] S_SETUP_B    = 4'd4;
  localparam logic [STEP_W-1:0] S_SWEEP_PASS = 4'd5;
  localparam logic [STEP_W-1:0] S_ROW        = 4'd6;
  localparam logic [STEP_W-1:0] S_READ       = 4'd7;
  localparam logic [STEP_W-1:0] S_MAX        = 4'd8;
  localparam logic [STEP_W-1:0] S_COST       = 4'd9;
  localparam logic [STEP_W-1:0] S_PICK       = 4'd10;
  localparam logic [STEP_W-1:0] S_WR_INIT    = 4'd11;
  localparam logic [STEP_W-1:0] S_WRITE      = 4'd12;
  localparam logic [STEP_W-1:0] S_EMIT       = 4'd13;
  localparam logic [STEP_W-1:0] S_EMIT_WAIT  = 4'd14;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Status flags from the datapath that the jump conditions test.
  typedef struct packed {
    logic no_item;
    logic no_pass;
    logic sweep_more;
    logic row_past;
    logic k_more;
    logic no_any;
    logic out_free;
  } flags_t;

  // The program. A word jumps to its target when its condition holds,
  // otherwise the step counter moves on by one.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] s);
    ucode_t w;
    case (s)
      S_CLR:        w = '{OP_CLR,     C_NONE,       S_CLR};
      S_SWEEP_RST:  w = '{OP_SWEEP,   C_SWEEP_MORE, S_SWEEP_RST};
      S_IDLE:       w = '{OP_ACCEPT,  C_NO_ITEM,    S_IDLE};
      S_SETUP_A:    w = '{OP_SETUP_A, C_NONE,       S_SETUP_A};
      S_SETUP_B:    w = '{OP_SETUP_B, C_NO_PASS,    S_ROW};
      S_SWEEP_PASS: w = '{OP_SWEEP,   C_SWEEP_MORE, S_SWEEP_PASS};
      S_ROW:        w = '{OP_ROW,     C_ROW_PAST,   S_WR_INIT};
      S_READ:       w = '{OP_READ,    C_NONE,       S_READ};
      S_MAX:        w = '{OP_MAX,     C_K_MORE,     S_READ};
      S_COST:       w = '{OP_COST,    C_NONE,       S_COST};
      S_PICK:       w = '{OP_PICK,    C_ALWAYS,     S_ROW};
      S_WR_INIT:    w = '{OP_WR_INIT, C_NO_ANY,     S_EMIT};
      S_WRITE:      w = '{OP_WRITE,   C_K_MORE,     S_WRITE};
      S_EMIT:       w = '{OP_EMIT,    C_OUT_FREE,   S_IDLE};
      S_EMIT_WAIT:  w = '{OP_NOP,     C_ALWAYS,     S_EMIT};
      default:      w = '{OP_NOP,     C_ALWAYS,     S_IDLE};
    endcase
    return w;
  endfunction

  // Zero-extends a coordinate into the signed working width.
  function automatic logic signed [CALC_W-1:0] to_s(input logic [COORD_W-1:0] v);
    return $signed(CALC_W'(v));
  endfunction

endpackage

FILE: rtl/rfl_if.sv
interface rfl_in_if;
  import rfl_pkg::*;
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  init_x;
  logic [COORD_W-1:0]  init_y;
  logic [WIDTH_W-1:0]  cell_width;
  logic [HEIGHT_W-1:0] cell_height;
  logic                new_pass;

  modport source (output valid, init_x, init_y, cell_width, cell_height, new_pass,
                  input ready);
  modport sink   (input valid, init_x, init_y, cell_width, cell_height, new_pass,
                  output ready);
endinterface

interface rfl_out_if;
  import rfl_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] place_x;
  logic [COORD_W-1:0] place_y;
  logic               found;

  modport source (output valid, place_x, place_y, found, input ready);
  modport sink   (input valid, place_x, place_y, found, output ready);
endinterface

interface rfl_cfg_if;
  import rfl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: rtl/row_frontier_cell_legalizer.sv
// Channel  | Role   | Handshake    | Word
// ---------+--------+--------------+-------------------------------------------------
// in_i     | sink   | valid/ready  | init_x, init_y, cell_width, cell_height, new_pass
// out_o    | source | valid/ready  | place_x, place_y, found
// cfg_i    | sink   | valid/ready  | index, wdata (ready always high)
//
// For each cell, h is the clamped height and the window holds at most 5h + 1
// candidate rows. The pace is set by the microcoded step loop, which reads the
// frontier words of each row one at a time from the single read port of the
// frontier RAM, with a read step and a max step per word. A word with new_pass
// set first runs a refill sweep over all NUM_ROWS rows. After reset a clearing
// pass zeroes the frontier RAM before the first word is taken. A finished
// result waits in the output register while the next word is processed; only
// the final emit step stalls if that register is still full.
module row_frontier_cell_legalizer #(
  parameter int NUM_ROWS   = rfl_pkg::DEF_NUM_ROWS,
  parameter int MAX_HEIGHT = rfl_pkg::DEF_MAX_HEIGHT
) (
  input logic       clk_i,
  input logic       rst_ni,
  rfl_in_if.sink    in_i,
  rfl_out_if.source out_o,
  rfl_cfg_if.sink   cfg_i
);
  import rfl_pkg::*;

  localparam int ROW_W = $clog2(NUM_ROWS);

  // Region registers. The right edge is accepted on the port but nothing
  // reads it, so it is not stored.
  logic [COORD_W-1:0] region_left_q;
  logic [COORD_W-1:0] region_bottom_q;
  logic [COORD_W-1:0] region_top_q;

  op_e                op;
  flags_t             flags;
  logic               mem_we;
  logic [ROW_W-1:0]   mem_waddr, mem_raddr;
  logic [COORD_W-1:0] mem_wdata, mem_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_left_q   <= '0;
      region_bottom_q <= '0;
      region_top_q    <= REGION_TOP_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_REGION_LEFT:   region_left_q   <= cfg_i.wdata;
        CFG_REGION_RIGHT:  begin
        end
        CFG_REGION_BOTTOM: region_bottom_q <= cfg_i.wdata;
        CFG_REGION_TOP:    region_top_q    <= cfg_i.wdata;
        default: begin
          // Indexes beyond the register list are dropped.
        end
      endcase
    end
  end

  // The sequencer steps through the control program; each word selects one
  // datapath operation and an optional conditional jump.
  rfl_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op)
  );

  rfl_dp #(
    .NUM_ROWS   (NUM_ROWS),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .flags_o         (flags),
    .in_i            (in_i),
    .out_o           (out_o),
    .region_left_i   (region_left_q),
    .region_bottom_i (region_bottom_q),
    .region_top_i    (region_top_q),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  // Row frontier store: one word per placement row.
  rfl_ram #(
    .WIDTH (COORD_W),
    .DEPTH (NUM_ROWS)
  ) u_frontier_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );
endmodule

FILE: rtl/rfl_ram.sv
module rfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/rfl_seq.sv
module rfl_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rfl_pkg::flags_t flags_i,
  output rfl_pkg::op_e    op_o
);
  import rfl_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uw;
  logic              take;

  assign uw   = ucode_rom(step_q);
  assign op_o = uw.op;

  always_comb begin
    case (uw.cond)
      C_NONE:       take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_ITEM:    take = flags_i.no_item;
      C_NO_PASS:    take = flags_i.no_pass;
      C_SWEEP_MORE: take = flags_i.sweep_more;
      C_ROW_PAST:   take = flags_i.row_past;
      C_K_MORE:     take = flags_i.k_more;
      C_NO_ANY:     take = flags_i.no_any;
      C_OUT_FREE:   take = flags_i.out_free;
      default:      take = 1'b0;
    endcase
    step_d = take ? uw.target : step_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_CLR;
    end else begin
      step_q <= step_d;
    end
  end
endmodule

FILE: rtl/rfl_dp.sv
module rfl_dp #(
  parameter int NUM_ROWS   = rfl_pkg::DEF_NUM_ROWS,
  parameter int MAX_HEIGHT = rfl_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rfl_pkg::op_e                  op_i,
  output rfl_pkg::flags_t               flags_o,
  rfl_in_if.sink                        in_i,
  rfl_out_if.source                     out_o,
  input  logic [rfl_pkg::COORD_W-1:0]   region_left_i,
  input  logic [rfl_pkg::COORD_W-1:0]   region_bottom_i,
  input  logic [rfl_pkg::COORD_W-1:0]   region_top_i,
  output logic                          mem_we_o,
  output logic [$clog2(NUM_ROWS)-1:0]   mem_waddr_o,
  output logic [rfl_pkg::COORD_W-1:0]   mem_wdata_o,
  output logic [$clog2(NUM_ROWS)-1:0]   mem_raddr_o,
  input  logic [rfl_pkg::COORD_W-1:0]   mem_rdata_i
);
  import rfl_pkg::*;

  localparam int ROW_W = $clog2(NUM_ROWS);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int HCW   = (HW > HEIGHT_W) ? HW : HEIGHT_W;

  // Latched item
  logic [COORD_W-1:0] ix_q;
  logic [COORD_W-1:0] iy_q;
  logic [WIDTH_W-1:0] w_q;
  logic [HW-1:0]      h_q;
  logic               np_q;

  // Window and scan state
  logic signed [CALC_W-1:0] d_q, span_q, row_q, last_q;
  logic [COORD_W-1:0]       floor_q, x_q, fill_q, edge_q;
  logic [CALC_W-1:0]        dxa_q, dya_q, best_cost_q;
  logic [COORD_W-1:0]       best_x_q;
  logic [ROW_W-1:0]         pick_row_q, cnt_q;
  logic [HW-1:0]            k_q;
  logic                     any_q;

  // Result register
  logic               out_valid_q;
  logic [COORD_W-1:0] px_q, py_q;
  logic               found_q;

  // Combinational helpers
  logic [HCW-1:0]           h_raw;
  logic [HW-1:0]            h_in;
  logic signed [CALC_W-1:0] hs, h2, h3, lo, first, lim_a, lim_b, lim_c, last;
  logic signed [CALC_W-1:0] fl_t, dx, dy;
  logic [CALC_W-1:0]        cost;
  logic [COORD_W:0]         edge_sum;
  logic                     out_free;

  always_comb begin
    h_raw = HCW'(in_i.cell_height);
    if (h_raw == '0) begin
      h_in = HW'(1);
    end else if (h_raw > HCW'(MAX_HEIGHT)) begin
      h_in = HW'(MAX_HEIGHT);
    end else begin
      h_in = HW'(h_raw);
    end

    hs    = $signed(CALC_W'(h_q));
    h2    = hs <<< 1;
    h3    = h2 + hs;
    lo    = d_q - h2;
    first = lo[CALC_W-1] ? '0 : lo;
    lim_a = span_q - hs;
    lim_b = d_q + h3;
    lim_c = $signed(CALC_W'(NUM_ROWS)) - hs;
    last  = (lim_a < lim_b) ? lim_a : lim_b;
    if (lim_c < last) begin
      last = lim_c;
    end

    fl_t = to_s(ix_q) - $signed(CALC_W'(w_q));
    dx   = to_s(x_q) - to_s(ix_q);
    dy   = row_q - d_q;
    cost = dxa_q + dya_q;

    edge_sum = {1'b0, best_x_q} + (COORD_W + 1)'(w_q);
  end

  assign out_free = !out_valid_q || out_o.ready;

  assign flags_o.no_item    = !in_i.valid;
  assign flags_o.no_pass    = !np_q;
  assign flags_o.sweep_more = (cnt_q != ROW_W'(NUM_ROWS - 1));
  assign flags_o.row_past   = (row_q > last_q);
  assign flags_o.k_more     = ((k_q + HW'(1)) != h_q);
  assign flags_o.no_any     = !any_q;
  assign flags_o.out_free   = out_free;

  assign in_i.ready = (op_i == OP_ACCEPT);

  assign out_o.valid   = out_valid_q;
  assign out_o.place_x = px_q;
  assign out_o.place_y = py_q;
  assign out_o.found   = found_q;

  assign mem_raddr_o = row_q[ROW_W-1:0] + ROW_W'(k_q);
  assign mem_we_o    = (op_i == OP_SWEEP) || (op_i == OP_WRITE);
  assign mem_waddr_o = (op_i == OP_SWEEP) ? cnt_q : pick_row_q + ROW_W'(k_q);
  assign mem_wdata_o = (op_i == OP_SWEEP) ? fill_q : edge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      fill_q      <= '0;
      k_q         <= '0;
      any_q       <= 1'b0;
      np_q        <= 1'b0;
    end else begin
      // A new result may be loaded in the same cycle as the old one leaves.
      if ((op_i == OP_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (op_i)
        OP_CLR: begin
          fill_q <= '0;
          cnt_q  <= '0;
        end
        OP_SWEEP: begin
          cnt_q <= cnt_q + ROW_W'(1);
        end
        OP_ACCEPT: begin
          ix_q <= in_i.init_x;
          iy_q <= in_i.init_y;
          w_q  <= in_i.cell_width;
          h_q  <= h_in;
          np_q <= in_i.new_pass;
        end
        OP_SETUP_A: begin
          d_q     <= to_s(iy_q) - to_s(region_bottom_i);
          span_q  <= to_s(region_top_i) - to_s(region_bottom_i);
          floor_q <= (fl_t > to_s(region_left_i)) ? fl_t[COORD_W-1:0] : region_left_i;
          fill_q  <= region_left_i;
          cnt_q   <= '0;
        end
        OP_SETUP_B: begin
          row_q  <= first;
          last_q <= last;
          any_q  <= 1'b0;
        end
        OP_ROW: begin
          x_q <= floor_q;
          k_q <= '0;
        end
        OP_READ: begin
          // Read data for row plus k lands in the RAM output register.
        end
        OP_MAX: begin
          if (mem_rdata_i > x_q) begin
            x_q <= mem_rdata_i;
          end
          k_q <= k_q + HW'(1);
        end
        OP_COST: begin
          dxa_q <= $unsigned(dx[CALC_W-1] ? -dx : dx);
          dya_q <= $unsigned(dy[CALC_W-1] ? -dy : dy);
        end
        OP_PICK: begin
          // Strict compare keeps the lowest row on equal cost.
          if (!any_q || (cost < best_cost_q)) begin
            any_q       <= 1'b1;
            best_cost_q <= cost;
            pick_row_q  <= row_q[ROW_W-1:0];
            best_x_q    <= x_q;
          end
          row_q <= row_q + CALC_W'(1);
        end
        OP_WR_INIT: begin
          edge_q <= edge_sum[COORD_W] ? '1 : edge_sum[COORD_W-1:0];
          k_q    <= '0;
        end
        OP_WRITE: begin
          k_q <= k_q + HW'(1);
        end
        OP_EMIT: begin
          if (out_free) begin
            found_q <= any_q;
            px_q    <= any_q ? best_x_q : '0;
            py_q    <= any_q ? COORD_W'(pick_row_q) + region_bottom_i : '0;
          end
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end
endmodule
